// ===== sv/frustum_cull_test_defines.svh =====
// Assertion macros shared by the frustum culling RTL.
`ifndef FRUSTUM_CULL_TEST_DEFINES_SVH
`define FRUSTUM_CULL_TEST_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define FCT_ASSERT_NOW(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define FCT_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== sv/fct_pkg.sv =====
// Types and constants shared by the frustum culling modules.
package fct_pkg;

    localparam int COORD_W   = 32;
    localparam int COEF_W    = COORD_W + 1;
    localparam int PROD_W    = COEF_W + COORD_W;
    localparam int PAIR_W    = PROD_W + 1;
    localparam int SUM_W     = PAIR_W + 1;
    localparam int D_SHIFT   = 16;
    localparam int CFG_W     = 2 * COORD_W;
    localparam int CFG_IDX_W = 3;
    localparam int ROW_COUNT = 4;
    localparam int AXIS_COUNT = 3;

    // Low bit of the register index selects the row pair of a column.
    localparam logic HALF_R01 = 1'b0;
    localparam logic HALF_R23 = 1'b1;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [COEF_W-1:0]  t_coef;

    typedef struct packed {
        logic                       kind;
        logic [AXIS_COUNT-1:0][COORD_W-1:0] lo;
        logic [AXIS_COUNT-1:0][COORD_W-1:0] hi;
        logic                       in_view;
    } t_item;

    // Column update broadcast to the cells: the full new column of the matrix.
    typedef struct packed {
        logic                              en;
        logic [1:0]                        col;
        logic [ROW_COUNT-1:0][COORD_W-1:0] e;
    } t_cfg_bus;

endpackage

// ===== sv/fct_cell.sv =====
// One plane cell: holds one clip plane and tests items flowing through it.
`include "frustum_cull_test_defines.svh"

module fct_cell
    import fct_pkg::*;
#(
    parameter int PLANE_IDX = 0
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg_bus i_cfg,
    input  logic     i_valid,
    input  t_item    i_item,
    output logic     o_stall,
    output logic     o_valid,
    output t_item    o_item,
    input  logic     i_stall
);

    localparam int  K_RAW = PLANE_IDX / 2;
    localparam int  K     = (K_RAW > 2) ? 2 : K_RAW;
    localparam bit  ADD   = ((PLANE_IDX % 2) == 0);

    t_coef r_coef [ROW_COUNT];

    logic                  r_a_valid, r_b_valid, r_c_valid;
    t_item                 r_a_item, r_b_item, r_c_item;
    logic signed [PROD_W-1:0] r_a_prod [AXIS_COUNT];
    t_coef                 r_a_d;
    logic signed [PAIR_W-1:0] r_b_s01, r_b_s2d;

    logic ready_a, ready_b, ready_c;
    logic signed [PROD_W-1:0] n_prod [AXIS_COUNT];
    t_coord                sel [AXIS_COUNT];
    logic signed [PAIR_W-1:0] n_s01, n_s2d;
    logic signed [SUM_W-1:0]  total;
    t_coef                 n_coef;
    t_coef                 e3, ek;
    t_item                 n_c_item;

    assign ready_c = !r_c_valid || !i_stall;
    assign ready_b = !r_b_valid || ready_c;
    assign ready_a = !r_a_valid || ready_b;
    assign o_stall = !ready_a;
    assign o_valid = r_c_valid;
    assign o_item  = r_c_item;

    // Plane coefficient j is row 3 plus or minus row K of column j.
    assign e3     = COEF_W'($signed(i_cfg.e[3]));
    assign ek     = COEF_W'($signed(i_cfg.e[K]));
    assign n_coef = ADD ? (e3 + ek) : (e3 - ek);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < ROW_COUNT; j++) begin
                r_coef[j] <= '0;
            end
        end else if (i_cfg.en) begin
            r_coef[i_cfg.col] <= n_coef;
        end
    end

    // Positive vertex per axis for boxes, the lower corner for points.
    always_comb begin
        for (int i = 0; i < AXIS_COUNT; i++) begin
            sel[i] = (i_item.kind && !r_coef[i][COEF_W-1]) ? t_coord'(i_item.hi[i])
                                                           : t_coord'(i_item.lo[i]);
            n_prod[i] = PROD_W'(r_coef[i]) * PROD_W'(sel[i]);
        end
    end

    assign n_s01 = PAIR_W'(r_a_prod[0]) + PAIR_W'(r_a_prod[1]);
    assign n_s2d = PAIR_W'(r_a_prod[2]) + (PAIR_W'(r_a_d) <<< D_SHIFT);
    assign total = SUM_W'(r_b_s01) + SUM_W'(r_b_s2d);

    // A negative distance clears the flag; it is never set again.
    always_comb begin
        n_c_item         = r_b_item;
        n_c_item.in_view = r_b_item.in_view && !total[SUM_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (ready_a) begin
                r_a_valid <= i_valid;
            end
            if (ready_b) begin
                r_b_valid <= r_a_valid;
            end
            if (ready_c) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_a) begin
            r_a_item <= i_item;
            r_a_d    <= r_coef[3];
            for (int i = 0; i < AXIS_COUNT; i++) begin
                r_a_prod[i] <= n_prod[i];
            end
        end
        if (ready_b) begin
            r_b_item <= r_a_item;
            r_b_s01  <= n_s01;
            r_b_s2d  <= n_s2d;
        end
        if (ready_c) begin
            r_c_item <= n_c_item;
        end
    end

    `FCT_ASSERT_NOW(a_stall_only_when_full,
        !o_stall || (r_a_valid && r_b_valid && r_c_valid),
        "cell stalls its upstream with a bubble inside")
    `FCT_ASSERT_NEXT(a_mid_holds,
        r_b_valid && !ready_c, r_b_valid,
        "middle stage dropped an item while the last stage was blocked")
    `FCT_ASSERT_NEXT(a_outside_sticks,
        ready_c && r_b_valid && !r_b_item.in_view, r_c_valid && !r_c_item.in_view,
        "an item already outside came back inside")

endmodule

// ===== sv/frustum_cull_test.sv =====
// Top level of the frustum culling block: matrix registers and the chain of plane cells.
//
// Usage: software writes the 4x4 view-projection matrix through the plain write
// port (i_cfg_we, i_cfg_index, i_cfg_wdata) while the block is idle. Each write
// carries two Q16.16 entries of one column; the six clip planes are rebuilt at
// the same clock edge, so an item may follow in the very next cycle.
// Items arrive on the input channel (i_valid, o_stall) as a kind bit and two
// corners; a point uses only the lower corner. One transfer on the output
// channel (o_valid, i_stall) carries inside_res for each item, in order.
// Six plane cells, each with a multiply stage, a pair-add stage and a final
// add with sign test, so 3 registers per cell. Throughput is one item per
// cycle while the receiver does not stall, set by the fully pipelined cell chain.
// When the receiver stalls, results pile up stage by stage; bubbles are
// squeezed out, and o_stall rises only once all 18 stages hold items.
// Reset clears the matrix and all planes to zero, which makes every item inside
// until software loads a matrix, and empties the pipeline.
`include "frustum_cull_test_defines.svh"

module frustum_cull_test
    import fct_pkg::*;
#(
    parameter int PLANE_COUNT = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_kind,
    input  logic signed [COORD_W-1:0] i_lo_x,
    input  logic signed [COORD_W-1:0] i_lo_y,
    input  logic signed [COORD_W-1:0] i_lo_z,
    input  logic signed [COORD_W-1:0] i_hi_x,
    input  logic signed [COORD_W-1:0] i_hi_y,
    input  logic signed [COORD_W-1:0] i_hi_z,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_inside_res
);

    // Matrix held by column; the cells keep only the derived planes, so the
    // untouched row pair of a column is read back here on every write.
    logic [ROW_COUNT-1:0][COORD_W-1:0] r_mat [ROW_COUNT];
    t_cfg_bus cfg_bus;

    always_comb begin
        cfg_bus.en  = i_cfg_we;
        cfg_bus.col = i_cfg_index[CFG_IDX_W-1:1];
        cfg_bus.e   = r_mat[i_cfg_index[CFG_IDX_W-1:1]];
        unique case (i_cfg_index[0])
            HALF_R01: begin
                cfg_bus.e[0] = i_cfg_wdata[COORD_W-1:0];
                cfg_bus.e[1] = i_cfg_wdata[CFG_W-1:COORD_W];
            end
            HALF_R23: begin
                cfg_bus.e[2] = i_cfg_wdata[COORD_W-1:0];
                cfg_bus.e[3] = i_cfg_wdata[CFG_W-1:COORD_W];
            end
            default: begin
                cfg_bus.e = r_mat[i_cfg_index[CFG_IDX_W-1:1]];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < ROW_COUNT; c++) begin
                r_mat[c] <= '0;
            end
        end else if (cfg_bus.en) begin
            r_mat[cfg_bus.col] <= cfg_bus.e;
        end
    end

    // The item enters the chain marked inside; each cell can only clear it.
    logic [PLANE_COUNT:0] w_valid;
    logic [PLANE_COUNT:0] w_stall;
    t_item                w_item [PLANE_COUNT+1];

    always_comb begin
        w_item[0].kind    = i_kind;
        w_item[0].lo[0]   = i_lo_x;
        w_item[0].lo[1]   = i_lo_y;
        w_item[0].lo[2]   = i_lo_z;
        w_item[0].hi[0]   = i_hi_x;
        w_item[0].hi[1]   = i_hi_y;
        w_item[0].hi[2]   = i_hi_z;
        w_item[0].in_view = 1'b1;
    end

    assign w_valid[0]           = i_valid;
    assign o_stall              = w_stall[0];
    assign w_stall[PLANE_COUNT] = i_stall;
    assign o_valid              = w_valid[PLANE_COUNT];
    assign o_inside_res         = w_item[PLANE_COUNT].in_view;

    // Cells in plane order: left, right, bottom, top, near, far.
    for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_cell
        fct_cell #(
            .PLANE_IDX(p)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (cfg_bus),
            .i_valid (w_valid[p]),
            .i_item  (w_item[p]),
            .o_stall (w_stall[p]),
            .o_valid (w_valid[p+1]),
            .o_item  (w_item[p+1]),
            .i_stall (w_stall[p+1])
        );
    end

endmodule

// ===== test/frustum_cull_checker.sv =====
// Checker for the frustum culling block: plane predictor, expected-result queue and compare.
module frustum_cull_checker
    import fct_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic                 i_kind,
    input  t_coord               i_lo_x,
    input  t_coord               i_lo_y,
    input  t_coord               i_lo_z,
    input  t_coord               i_hi_x,
    input  t_coord               i_hi_y,
    input  t_coord               i_hi_z,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic                 i_inside_res,
    output int                   o_errors,
    output int                   o_pending
);

    localparam int PLANES     = 6;
    localparam int DIST_W     = 80;

    typedef struct {
        int   seq;
        logic in_view;
    } t_verdict;

    t_coord   mat_q   [ROW_COUNT][ROW_COUNT];  // [column][row]
    t_coef    plane_q [PLANES][ROW_COUNT];     // [plane][A, B, C, D]
    t_verdict inside_q [$];
    t_verdict head;
    t_coord   lo_v [AXIS_COUNT];
    t_coord   hi_v [AXIS_COUNT];
    int       err_cnt;
    int       in_seq;
    int       out_seq;

    task automatic report_mismatch(input string msg);
        $display("[%0t] frustum check: %s", $time, msg);
        err_cnt++;
    endtask

    // Plane pair k is row 3 plus and minus row k, one coefficient per column.
    function automatic void rebuild_planes();
        t_coef w;
        t_coef r;
        for (int p = 0; p < PLANES; p++) begin
            for (int j = 0; j < ROW_COUNT; j++) begin
                w = mat_q[j][3];
                r = mat_q[j][p >> 1];
                plane_q[p][j] = (p % 2 == 0) ? w + r : w - r;
            end
        end
    endfunction

    // Exact sign of A*x + B*y + C*z + D per plane, on the positive vertex for a box.
    function automatic logic predict_inside(input logic is_box,
                                            input t_coord lo [AXIS_COUNT],
                                            input t_coord hi [AXIS_COUNT]);
        logic signed [DIST_W-1:0] acc;
        t_coord                   pt;
        logic                     result;
        result = 1'b1;
        for (int p = 0; p < PLANES; p++) begin
            acc = plane_q[p][3];
            acc = acc <<< D_SHIFT;
            for (int a = 0; a < AXIS_COUNT; a++) begin
                pt = (is_box && plane_q[p][a] >= 0) ? hi[a] : lo[a];
                acc = acc + plane_q[p][a] * pt;
            end
            if (acc < 0) begin
                result = 1'b0;
            end
        end
        return result;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (mat_q[c, r]) begin
                mat_q[c][r] = '0;
            end
            rebuild_planes();
            inside_q.delete();
            err_cnt = 0;
            in_seq  = 0;
            out_seq = 0;
        end else begin
            // Items see the planes as they stood before any write at this same edge.
            if (i_in_valid && !i_in_stall) begin
                lo_v = '{i_lo_x, i_lo_y, i_lo_z};
                hi_v = '{i_hi_x, i_hi_y, i_hi_z};
                inside_q.push_back('{in_seq, predict_inside(i_kind, lo_v, hi_v)});
                in_seq++;
            end
            if (i_out_valid && !i_out_stall) begin
                if (inside_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              out_seq));
                end else begin
                    head = inside_q.pop_front();
                    if (i_inside_res !== head.in_view) begin
                        report_mismatch($sformatf("item %0d inside_res %b, expected %b",
                                                  head.seq, i_inside_res, head.in_view));
                    end
                end
                out_seq++;
            end
            if (i_cfg_we) begin
                if (i_cfg_index[0] == HALF_R23) begin
                    mat_q[i_cfg_index[CFG_IDX_W-1:1]][2] = i_cfg_wdata[COORD_W-1:0];
                    mat_q[i_cfg_index[CFG_IDX_W-1:1]][3] = i_cfg_wdata[CFG_W-1:COORD_W];
                end else begin
                    mat_q[i_cfg_index[CFG_IDX_W-1:1]][0] = i_cfg_wdata[COORD_W-1:0];
                    mat_q[i_cfg_index[CFG_IDX_W-1:1]][1] = i_cfg_wdata[CFG_W-1:COORD_W];
                end
                rebuild_planes();
            end
        end
        o_errors  <= err_cnt;
        o_pending <= inside_q.size();
    end

endmodule

// ===== test/testbench.sv =====
// Top of the frustum culling testbench: clock, reset, stimulus, watchdog and verdict.
//
// The block is driven through three ports: the matrix write port and the two
// valid/stall channels. A checker instance beside the block watches every
// transfer, predicts inside_res from its own copy of the matrix and planes, and
// hands back a mismatch count and the number of results still outstanding.
// This module only makes stimulus and gives the final verdict.
//
// The run first goes through a short directed part: items under the reset
// matrix (all planes zero, so everything is inside), then under an identity
// matrix with points exactly on and just past the unit cube faces, boxes with
// min above max, points whose unused upper corner carries garbage, and
// coordinate extremes; then under matrices of all largest, all smallest and
// mixed extreme entries. After that come random phases. Each phase loads a
// new matrix (sometimes only some of the registers) while the block is idle,
// then sends a burst of random points and boxes.
module testbench;
    import fct_pkg::*;

    localparam int     PHASES          = 12;
    localparam int     ITEMS_PER_PHASE = 50;
    localparam int     DRAIN_CYCLES    = 40;
    localparam int     WATCHDOG_LIMIT  = 2000;
    localparam int     MAX_GAP         = 19;
    localparam t_coord ONE             = 32'sh0001_0000;
    localparam t_coord C_MAX           = 32'sh7FFF_FFFF;
    localparam t_coord C_MIN           = 32'sh8000_0000;
    localparam t_coord LSB             = 32'sh0000_0001;
    localparam logic   KIND_POINT      = 1'b0;
    localparam logic   KIND_BOX        = 1'b1;

    typedef enum int {
        MX_SCALED,
        MX_PERSP,
        MX_SMALL,
        MX_FULL,
        MX_EXTREME
    } t_mx_mode;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 i_valid     = 1'b0;
    logic                 o_stall;
    logic                 i_kind      = KIND_POINT;
    t_coord               i_lo_x      = '0;
    t_coord               i_lo_y      = '0;
    t_coord               i_lo_z      = '0;
    t_coord               i_hi_x      = '0;
    t_coord               i_hi_y      = '0;
    t_coord               i_hi_z      = '0;
    logic                 o_valid;
    logic                 i_stall     = 1'b0;
    logic                 o_inside_res;

    int     check_errors;
    int     check_pending;
    int     idle_cycles = 0;
    bit     no_gaps     = 1'b0;   // Set for stretches in which neither side idles.
    t_coord m_cur [ROW_COUNT][ROW_COUNT];  // Matrix being loaded, [column][row].

    frustum_cull_test i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_kind      (i_kind),
        .i_lo_x      (i_lo_x),
        .i_lo_y      (i_lo_y),
        .i_lo_z      (i_lo_z),
        .i_hi_x      (i_hi_x),
        .i_hi_y      (i_hi_y),
        .i_hi_z      (i_hi_z),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_inside_res(o_inside_res)
    );

    frustum_cull_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_kind      (i_kind),
        .i_lo_x      (i_lo_x),
        .i_lo_y      (i_lo_y),
        .i_lo_z      (i_lo_z),
        .i_hi_x      (i_hi_x),
        .i_hi_y      (i_hi_y),
        .i_hi_z      (i_hi_z),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_inside_res(o_inside_res),
        .o_errors    (check_errors),
        .o_pending   (check_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The watchdog counts cycles in which no transfer and no register write happens.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[frustum_cull_test] ERROR");
            $finish;
        end
    end

    // Receiver: before each result it holds stall high for a random number of cycles,
    // then keeps stall low until one transfer has gone through.
    initial begin
        int wait_cycles;
        wait (i_rst_n);
        forever begin
            wait_cycles = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
            if (wait_cycles > 0) begin
                i_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Sends one item after a random gap and returns at the edge that takes it.
    // Valid is only lowered when a gap follows, so back-to-back items keep it high.
    task automatic push_item(input logic kind, input t_coord lx, input t_coord ly,
                             input t_coord lz, input t_coord hx, input t_coord hy,
                             input t_coord hz);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind  <= kind;
        i_lo_x  <= lx;
        i_lo_y  <= ly;
        i_lo_z  <= lz;
        i_hi_x  <= hx;
        i_hi_y  <= hy;
        i_hi_z  <= hz;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Ends the current burst and waits until every expected result has come back.
    task automatic settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (check_pending != 0);
    endtask

    // Writes the registers selected by the mask from m_cur, one per cycle.
    task automatic load_matrix(input logic [7:0] mask);
        logic [CFG_IDX_W-1:0] idx;
        int                   row;
        for (int col = 0; col < ROW_COUNT; col++) begin
            for (int h = 0; h < 2; h++) begin
                idx = CFG_IDX_W'(col * 2 + h);
                row = (idx[0] == HALF_R23) ? 2 : 0;
                if (mask[idx]) begin
                    i_cfg_we    <= 1'b1;
                    i_cfg_index <= idx;
                    i_cfg_wdata <= {m_cur[col][row+1], m_cur[col][row]};
                    @(posedge i_clk);
                end
            end
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_coord pick_small(input int range);
        int v;
        v = int'($urandom_range(0, 2 * range)) - range;
        return t_coord'(v);
    endfunction

    function automatic t_coord pick_extreme();
        case ($urandom_range(0, 5))
            0:       return C_MAX;
            1:       return C_MIN;
            2:       return '0;
            3:       return -LSB;
            4:       return ONE;
            default: return -ONE;
        endcase
    endfunction

    // Mostly coordinates near the unit cube, some full-range and some extreme ones.
    function automatic t_coord pick_coord();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 14) begin
            return pick_small(4 * ONE);
        end else if (sel < 17) begin
            return t_coord'($urandom);
        end
        return pick_extreme();
    endfunction

    task automatic fill_matrix(input t_mx_mode mode);
        foreach (m_cur[c, r]) begin
            case (mode)
                MX_SMALL:   m_cur[c][r] = pick_small(2 * ONE);
                MX_FULL:    m_cur[c][r] = t_coord'($urandom);
                MX_EXTREME: m_cur[c][r] = pick_extreme();
                default:    m_cur[c][r] = ($urandom_range(0, 7) == 0) ? pick_small(ONE / 8) : '0;
            endcase
        end
        if (mode == MX_SCALED) begin
            // A scaled and shifted box in clip space.
            for (int a = 0; a < AXIS_COUNT; a++) begin
                m_cur[a][a] = t_coord'($urandom_range(ONE / 4, 4 * ONE));
                m_cur[3][a] = pick_small(ONE / 2);
            end
            m_cur[3][3] = ONE;
        end else if (mode == MX_PERSP) begin
            // A perspective projection with w taken from -z.
            m_cur[0][0] = t_coord'($urandom_range(ONE / 2, 2 * ONE));
            m_cur[1][1] = t_coord'($urandom_range(ONE / 2, 2 * ONE));
            m_cur[2][2] = -t_coord'($urandom_range(ONE, 2 * ONE));
            m_cur[3][2] = -t_coord'($urandom_range(ONE / 8, ONE));
            m_cur[2][3] = -ONE;
            m_cur[3][3] = '0;
        end
    endtask

    initial begin
        logic        kind;
        t_coord      lo [AXIS_COUNT];
        t_coord      hi [AXIS_COUNT];
        t_coord      tmp;
        logic [7:0]  mask;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset matrix: every plane is zero, so every item is inside.
        push_item(KIND_POINT, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN);
        push_item(KIND_BOX, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
        settle();

        // Identity: the unit cube, with distance zero on its faces.
        foreach (m_cur[c, r]) begin
            m_cur[c][r] = (c == r) ? ONE : '0;
        end
        load_matrix(8'hFF);
        push_item(KIND_POINT, '0, '0, '0, '0, '0, '0);
        push_item(KIND_POINT, ONE, ONE, ONE, '0, '0, '0);
        push_item(KIND_POINT, ONE + LSB, '0, '0, '0, '0, '0);
        push_item(KIND_POINT, -ONE, -ONE, -ONE, '0, '0, '0);
        push_item(KIND_POINT, '0, '0, -ONE - LSB, '0, '0, '0);
        // The upper corner of a point must be ignored, garbage or not.
        push_item(KIND_POINT, '0, '0, '0, C_MAX, C_MIN, C_MAX);
        push_item(KIND_BOX, -3 * ONE, -3 * ONE, -3 * ONE, -2 * ONE, -2 * ONE, -2 * ONE);
        push_item(KIND_BOX, -3 * ONE, -3 * ONE, -3 * ONE, 3 * ONE, 3 * ONE, 3 * ONE);
        push_item(KIND_BOX, 2 * ONE, '0, '0, 3 * ONE, '0, '0);
        // Boxes whose minimum lies above the maximum are used as given.
        push_item(KIND_BOX, ONE / 2, ONE / 2, ONE / 2, -ONE / 2, -ONE / 2, -ONE / 2);
        push_item(KIND_BOX, 3 * ONE, '0, '0, -3 * ONE, '0, '0);
        push_item(KIND_POINT, C_MIN, C_MIN, C_MIN, '0, '0, '0);
        settle();

        // Largest entries everywhere: plane sums reach the top of the coefficient range.
        foreach (m_cur[c, r]) m_cur[c][r] = C_MAX;
        load_matrix(8'hFF);
        push_item(KIND_POINT, C_MAX, C_MAX, C_MAX, '0, '0, '0);
        push_item(KIND_POINT, C_MIN, C_MIN, C_MIN, '0, '0, '0);
        settle();

        // Smallest entries everywhere: plane sums reach the bottom of the range.
        foreach (m_cur[c, r]) m_cur[c][r] = C_MIN;
        load_matrix(8'hFF);
        push_item(KIND_POINT, C_MAX, C_MAX, C_MAX, '0, '0, '0);
        push_item(KIND_BOX, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
        settle();

        // Checkerboard of extremes: differences reach both ends of the range.
        foreach (m_cur[c, r]) m_cur[c][r] = ((c + r) % 2 == 0) ? C_MAX : C_MIN;
        load_matrix(8'hFF);
        push_item(KIND_BOX, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
        push_item(KIND_POINT, '0, '0, '0, '0, '0, '0);
        push_item(KIND_BOX, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN);
        settle();

        // Random phases: a new matrix, then a burst of random points and boxes.
        for (int ph = 0; ph < PHASES; ph++) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            fill_matrix(t_mx_mode'($urandom_range(MX_SCALED, MX_EXTREME)));
            // Now and then only some registers are rewritten over the last matrix.
            mask = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'hFF;
            load_matrix(mask);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                kind = ($urandom_range(0, 1) == 0) ? KIND_POINT : KIND_BOX;
                for (int a = 0; a < AXIS_COUNT; a++) begin
                    lo[a] = pick_coord();
                    hi[a] = pick_coord();
                    // Most boxes are well formed; the rest keep min above max.
                    if (kind == KIND_BOX && lo[a] > hi[a] && $urandom_range(0, 6) != 0) begin
                        tmp   = lo[a];
                        lo[a] = hi[a];
                        hi[a] = tmp;
                    end
                end
                push_item(kind, lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
            end
            settle();
        end
        no_gaps = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (check_errors == 0 && check_pending == 0) begin
            $display("[frustum_cull_test] OK");
        end else begin
            $display("[frustum_cull_test] ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/fct_pkg.sv
sv/fct_cell.sv
sv/frustum_cull_test.sv
test/frustum_cull_checker.sv
test/testbench.sv
